// ===== hdl/ssq_pkg.sv =====
// Package for the single-server queue event step block.
// Holds the sequencer state type, the opcode, event kind, register and average codes.
// No dependencies.
`timescale 1ns / 1ps

package ssq_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL_T,
		ST_MUL_Q,
		ST_UPD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} ssq_state_t;

	// Input opcodes
	localparam logic OP_STEP   = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// Result event kinds
	localparam logic [1:0] KIND_ARRIVAL   = 2'd0;
	localparam logic [1:0] KIND_DEPARTURE = 2'd1;
	localparam logic [1:0] KIND_PAST      = 2'd2;
	localparam logic [1:0] KIND_REPORT    = 2'd3;

	// Configuration register indexes
	localparam logic CFG_TIME_LIMIT    = 1'b0;
	localparam logic CFG_FIRST_ARRIVAL = 1'b1;

	// Report averages, in the order they are computed
	localparam int          NUM_AVG        = 6;
	localparam logic [2:0]  AVG_SOJOURN    = 3'd0;
	localparam logic [2:0]  AVG_WAIT       = 3'd1;
	localparam logic [2:0]  AVG_IN_SYSTEM  = 3'd2;
	localparam logic [2:0]  AVG_UTIL       = 3'd3;
	localparam logic [2:0]  AVG_ARR_RATE   = 3'd4;
	localparam logic [2:0]  AVG_SVC_RATE   = 3'd5;

	// Long division: 128-bit dividend, one quotient bit per cycle
	localparam int DIV_STEPS = 128;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

endpackage

// ===== hdl/ssq_mul_acc.sv =====
// Shared multiplier for the area products: delta times a piece count,
// 16 bits of delta per cycle, saturated to 64 bits. Uses ssq_pkg.
`timescale 1ns / 1ps

module ssq_mul_acc import ssq_pkg::*; #(
	parameter int TIME_BITS  = 32,
	parameter int QUEUE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [TIME_BITS-1:0]  delta,
	input  logic [QUEUE_BITS:0]   mult,
	output logic                  done,
	output logic [63:0]           product
);

	localparam int NCH = (TIME_BITS + 15) / 16;
	localparam int DW  = NCH * 16;
	localparam int PPW = 16 + QUEUE_BITS + 1;
	localparam int PW  = DW + QUEUE_BITS + 1;
	localparam int EW  = (PW > 64) ? PW : 65;
	localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;

	logic [DW-1:0]       dlt_q;
	logic [QUEUE_BITS:0] mult_q;
	logic [PW-1:0]       prod_q;
	logic [CW-1:0]       cnt_q;
	logic                run_q;
	logic                done_q;
	logic [PPW-1:0]      pp;
	logic [EW-1:0]       prod_ext;

	// Top chunk of delta times the count
	assign pp = dlt_q[DW-1 -: 16] * mult_q;

	// Walk delta from the top chunk down, shift and add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				cnt_q  <= CW'(NCH - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dlt_q  <= DW'(delta);
			mult_q <= mult;
			prod_q <= '0;
		end else if (run_q) begin
			dlt_q  <= dlt_q << 16;
			prod_q <= (prod_q << 16) + PW'(pp);
		end
	end

	// Saturate to 64 bits
	assign prod_ext = EW'(prod_q);
	assign product  = (|prod_ext[EW-1:64]) ? {64{1'b1}} : prod_ext[63:0];
	assign done     = done_q;

endmodule

// ===== hdl/ssq_divider.sv =====
// Restoring long divider for the report averages: 128-bit dividend over 64-bit
// divisor, one bit per cycle, quotient saturated to 32 bits. Uses ssq_pkg.
`timescale 1ns / 1ps

module ssq_divider import ssq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [127:0]  dividend,
	input  logic [63:0]   divisor,
	output logic          done,
	output logic [31:0]   quotient
);

	logic [127:0]       dvd_q;
	logic [63:0]        den_q;
	logic [63:0]        rem_q;
	logic [31:0]        quo_q;
	logic               sat_q;
	logic               zero_q;
	logic [DIV_CW-1:0]  cnt_q;
	logic               run_q;
	logic               done_q;
	logic [64:0]        rx;
	logic [64:0]        rdiff;
	logic               ge;

	// One restoring step
	assign rx    = {rem_q, dvd_q[127]};
	assign rdiff = rx - {1'b0, den_q};
	assign ge    = (rx >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= (divisor != '0);
				done_q <= (divisor == '0);
				cnt_q <= DIV_CW'(DIV_STEPS - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			den_q  <= divisor;
			rem_q  <= '0;
			quo_q  <= '0;
			sat_q  <= 1'b0;
			zero_q <= (divisor == '0);
		end else if (run_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= ge ? rdiff[63:0] : rx[63:0];
			quo_q <= {quo_q[30:0], ge};
			// A set top bit shifted out means the quotient passed 32 bits
			if (quo_q[31])
				sat_q <= 1'b1;
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? '0 : (sat_q ? {32{1'b1}} : quo_q);

endmodule

// ===== hdl/single_server_queue_event_step.sv =====
// Top level of the single-server queue event step block.
// Sequencer, queue state, area accumulators and output register.
// Uses ssq_pkg, ssq_mul_acc and ssq_divider.
`timescale 1ns / 1ps

// Usage:
// Each beat on the s_axis side is one command: tuser 0 runs the next queue
// event using the two random draws in tdata, tuser 1 closes the run and
// reports six averages. Every command returns exactly one beat on m_axis.
// The cfg port writes time_limit (index 0) and first_arrival_time (index 1);
// the user must write only while no command is in flight, a rule the block
// leaves unchecked. A first_arrival_time write also reloads the pending
// arrival until the first arrival has been processed. An event step goes
// from accept through event choice, both area products and the update to the
// result register: the shared 16-bit-slice multiplier forms the total and
// queue area products one after the other. A past-limit step goes from event
// choice to output. A report adds six long divisions on the single divider.
// s_axis_tready is high only while the sequencer is idle; one item is worked
// on at a time. The result register lets the next command be accepted while
// a result still waits; if the receiver stalls, the sequencer holds at its
// final step until the register frees up. Reset clears the queue, the clock,
// the counters and areas, and both registers.

module single_server_queue_event_step import ssq_pkg::*; #(
	parameter int TIME_BITS  = 32,
	parameter int QUEUE_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// [31:0] interarrival_draw, [63:32] service_draw
	input  logic [63:0]   s_axis_tdata,
	// [0] opcode
	input  logic [0:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// [31:0] clock_now, [47:32] queue_count, [48] busy_res, [80:49] arrived_count,
	// [112:81] produced_count, [144:113] mean_sojourn, [176:145] mean_wait,
	// [208:177] mean_in_system, [240:209] utilization_pct, [272:241] arrival_rate,
	// [304:273] service_rate_seen, [311:305] zero
	output logic [311:0]  m_axis_tdata,
	// [1:0] event_kind
	output logic [1:0]    m_axis_tuser,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	localparam logic [TIME_BITS-1:0]  TMAX = {TIME_BITS{1'b1}};
	localparam logic [QUEUE_BITS-1:0] QMAX = {QUEUE_BITS{1'b1}};

	ssq_state_t state_q, state_d;

	logic [31:0]            time_limit_q;
	logic [TIME_BITS-1:0]   clock_q;
	logic [TIME_BITS-1:0]   next_arr_q;
	logic [TIME_BITS-1:0]   next_dep_q;
	logic                   busy_q;
	logic [QUEUE_BITS-1:0]  waiting_q;
	logic [31:0]            arrivals_q;
	logic [31:0]            departures_q;
	logic [63:0]            area_total_q;
	logic [63:0]            area_queue_q;
	logic [63:0]            area_busy_q;
	logic                   opcode_q;
	logic [31:0]            ia_q;
	logic [31:0]            sv_q;
	logic [1:0]             kind_q;
	logic [TIME_BITS-1:0]   delta_q;
	logic [2:0]             div_idx_q;
	logic [31:0]            avg_q [NUM_AVG];

	logic                   m_valid_q;
	logic [311:0]           m_data_q;
	logic [1:0]             m_user_q;

	logic [TIME_BITS-1:0]   lim;
	logic                   dep_due;
	logic                   arr_due;
	logic                   past;
	logic                   take_arr;
	logic [1:0]             eval_kind;
	logic [TIME_BITS:0]     eval_delta;
	logic [63:0]            eval_delta64;
	logic [QUEUE_BITS:0]    prod_cnt;
	logic [63:0]            area_prod;
	logic                   out_free;
	logic                   accept;

	logic                   mul_start;
	logic [QUEUE_BITS:0]    mul_b;
	logic                   mul_done;
	logic [63:0]            mul_prod;

	logic                   div_start;
	logic [127:0]           div_dvd;
	logic [63:0]            div_den;
	logic                   div_done;
	logic [31:0]            div_quo;

	logic [63:0]            div_x;
	logic                   div_m100;
	logic [1:0]             div_sh;
	logic [70:0]            x25;
	logic [70:0]            xm;

	function automatic logic [TIME_BITS-1:0] time_add(input logic [TIME_BITS-1:0] t,
			input logic [31:0] d);
		logic [TIME_BITS:0] s;
		s = {1'b0, t} + {1'b0, TIME_BITS'(d)};
		return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
	endfunction

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

	// Shared units
	ssq_mul_acc #(
		.TIME_BITS  (TIME_BITS),
		.QUEUE_BITS (QUEUE_BITS)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.delta   (eval_delta[TIME_BITS-1:0]),
		.mult    (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	ssq_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Event choice
	assign lim      = TIME_BITS'(time_limit_q);
	assign dep_due  = busy_q && (next_dep_q <= lim);
	assign arr_due  = (next_arr_q <= lim);
	assign past     = (clock_q > lim) || (!dep_due && !arr_due);
	assign take_arr = !busy_q || (next_arr_q < next_dep_q);

	always_comb begin
		if (opcode_q == OP_FINISH) begin
			eval_kind  = KIND_REPORT;
			eval_delta = (lim > clock_q) ? {1'b0, lim - clock_q} : '0;
		end else if (past) begin
			eval_kind  = KIND_PAST;
			eval_delta = '0;
		end else if (take_arr) begin
			eval_kind  = KIND_ARRIVAL;
			eval_delta = {1'b0, next_arr_q} - {1'b0, clock_q};
		end else begin
			eval_kind  = KIND_DEPARTURE;
			eval_delta = {1'b0, next_dep_q} - {1'b0, clock_q};
		end
	end

	// An event behind the clock gives a wrapped 64-bit delta; its product
	// is zero, the delta itself, or saturated for a count of 0, 1 or more
	assign eval_delta64 = {{(63 - TIME_BITS){eval_delta[TIME_BITS]}}, eval_delta};
	assign prod_cnt     = (state_q == ST_MUL_Q) ? {1'b0, waiting_q} :
		({1'b0, waiting_q} + {{QUEUE_BITS{1'b0}}, busy_q});
	assign area_prod    = !eval_delta[TIME_BITS] ? mul_prod :
		((prod_cnt == '0) ? '0 :
		((prod_cnt == {{QUEUE_BITS{1'b0}}, 1'b1}) ? eval_delta64 : {64{1'b1}}));

	// Dividend and divisor of the current average
	always_comb begin
		case (div_idx_q)
			AVG_SOJOURN: begin
				div_x = area_total_q; div_m100 = 1'b0; div_sh = 2'd0;
				div_den = 64'(arrivals_q);
			end
			AVG_WAIT: begin
				div_x = area_queue_q; div_m100 = 1'b0; div_sh = 2'd0;
				div_den = 64'(arrivals_q);
			end
			AVG_IN_SYSTEM: begin
				div_x = area_total_q; div_m100 = 1'b0; div_sh = 2'd1;
				div_den = 64'(lim);
			end
			AVG_UTIL: begin
				div_x = area_busy_q; div_m100 = 1'b1; div_sh = 2'd1;
				div_den = 64'(lim);
			end
			AVG_ARR_RATE: begin
				div_x = 64'(arrivals_q); div_m100 = 1'b0; div_sh = 2'd2;
				div_den = 64'(lim);
			end
			default: begin
				div_x = 64'(departures_q); div_m100 = 1'b0; div_sh = 2'd2;
				div_den = area_busy_q;
			end
		endcase
	end

	// Times 100 as (x*25) << 2
	assign x25 = (71'(div_x) << 4) + (71'(div_x) << 3) + 71'(div_x);
	assign xm  = div_m100 ? (x25 << 2) : 71'(div_x);

	always_comb begin
		case (div_sh)
			2'd1:    div_dvd = 128'(xm) << 16;
			2'd2:    div_dvd = 128'(xm) << 32;
			default: div_dvd = 128'(xm);
		endcase
	end

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and unit strobes
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		mul_b     = {1'b0, waiting_q} + {{QUEUE_BITS{1'b0}}, busy_q};
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = (eval_kind == KIND_PAST) ? ST_OUT : ST_MUL_T;
			end
			ST_MUL_T: begin
				// The first product starts on entry; wait for it
				if (mul_done) begin
					mul_start = 1'b1;
					mul_b     = {1'b0, waiting_q};
					state_d   = ST_MUL_Q;
				end
			end
			ST_MUL_Q: begin
				if (mul_done)
					state_d = ST_UPD;
			end
			ST_UPD: begin
				state_d = (kind_q == KIND_REPORT) ? ST_DIV_GO : ST_OUT;
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done)
					state_d = (div_idx_q == AVG_SVC_RATE) ? ST_OUT : ST_DIV_GO;
			end
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		// Total area product starts as the event is chosen
		if (state_q == ST_EVAL && eval_kind != KIND_PAST)
			mul_start = 1'b1;
	end

	// Queue state and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_limit_q <= '0;
			clock_q      <= '0;
			next_arr_q   <= '0;
			next_dep_q   <= TMAX;
			busy_q       <= 1'b0;
			waiting_q    <= '0;
			arrivals_q   <= '0;
			departures_q <= '0;
			area_total_q <= '0;
			area_queue_q <= '0;
			area_busy_q  <= '0;
			kind_q       <= KIND_PAST;
			div_idx_q    <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_TIME_LIMIT) begin
					time_limit_q <= cfg_data;
				end else begin
					if (arrivals_q == '0)
						next_arr_q <= TIME_BITS'(cfg_data);
				end
			end
			case (state_q)
				ST_EVAL: begin
					kind_q      <= eval_kind;
					div_idx_q   <= AVG_SOJOURN;
					if (eval_kind != KIND_PAST && busy_q)
						area_busy_q <= sat_add64(area_busy_q, eval_delta64);
				end
				ST_MUL_T: begin
					if (mul_done)
						area_total_q <= sat_add64(area_total_q, area_prod);
				end
				ST_MUL_Q: begin
					if (mul_done)
						area_queue_q <= sat_add64(area_queue_q, area_prod);
				end
				ST_UPD: begin
					case (kind_q)
						KIND_ARRIVAL: begin
							if (arrivals_q != '1)
								arrivals_q <= arrivals_q + 1'b1;
							clock_q    <= next_arr_q;
							next_arr_q <= time_add(next_arr_q, ia_q);
							if (!busy_q) begin
								busy_q     <= 1'b1;
								next_dep_q <= time_add(next_arr_q, sv_q);
							end else if (waiting_q != QMAX) begin
								waiting_q <= waiting_q + 1'b1;
							end
						end
						KIND_DEPARTURE: begin
							if (departures_q != '1)
								departures_q <= departures_q + 1'b1;
							clock_q <= next_dep_q;
							if (waiting_q != '0) begin
								waiting_q  <= waiting_q - 1'b1;
								next_dep_q <= time_add(next_dep_q, sv_q);
							end else begin
								busy_q     <= 1'b0;
								next_dep_q <= TMAX;
							end
						end
						KIND_REPORT: begin
							clock_q <= clock_q + delta_q;
						end
						default: begin
						end
					endcase
				end
				ST_DIV_WAIT: begin
					if (div_done)
						div_idx_q <= div_idx_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Command latch, delta and averages
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_q <= s_axis_tuser[0];
			ia_q     <= s_axis_tdata[31:0];
			sv_q     <= s_axis_tdata[63:32];
		end
		if (state_q == ST_EVAL)
			delta_q <= eval_delta[TIME_BITS-1:0];
		if (state_q == ST_DIV_WAIT && div_done)
			avg_q[div_idx_q] <= div_quo;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_user_q <= kind_q;
			m_data_q <= {7'd0,
				(kind_q == KIND_REPORT) ?
					{avg_q[AVG_SVC_RATE], avg_q[AVG_ARR_RATE], avg_q[AVG_UTIL],
					avg_q[AVG_IN_SYSTEM], avg_q[AVG_WAIT], avg_q[AVG_SOJOURN]} :
					192'd0,
				departures_q, arrivals_q, busy_q, 16'(waiting_q), 32'(clock_q)};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// An idle server has nobody waiting and no departure pending
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (waiting_q == '0 && next_dep_q == TMAX))
		else $error("idle server with pieces waiting or a departure pending");

	// Departures never outrun arrivals
	a_dep_le_arr: assert property (@(posedge clk) disable iff (!arst_n)
		departures_q <= arrivals_q)
		else $error("more departures than arrivals");

	// An accepted beat goes straight to event choice
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EVAL)
		else $error("accepted beat did not enter event choice");

	// The divider only runs for a report
	a_div_report: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> kind_q == KIND_REPORT)
		else $error("divider started outside a report");

endmodule

// ===== bench/tb_single_server_queue_event_step.sv =====
// Testbench for the single-server queue event step block.
// Drives event and finish beats, predicts every result beat and compares it field by field.
// Depends on ssq_pkg and single_server_queue_event_step.
`timescale 1ns / 1ps

module tb_single_server_queue_event_step;
	import ssq_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] clock_now;
		logic [15:0] queue_count;
		logic        busy;
		logic [31:0] arrived;
		logic [31:0] produced;
		logic [31:0] sojourn;
		logic [31:0] wait_avg;
		logic [31:0] in_system;
		logic [31:0] util;
		logic [31:0] arr_rate;
		logic [31:0] svc_rate;
	} ssq_result_t;

	// Queue model plus the store of expected result beats
	class queue_scoreboard;
		bit [31:0] time_limit, first_arrival;
		bit [31:0] sim_clock, next_arr, next_dep;
		bit        busy;
		bit [15:0] waiting;
		bit [31:0] arrivals, departures;
		bit [63:0] area_total, area_queue, area_busy;
		ssq_result_t pending[$];
		int errors;
		int n_arr, n_dep, n_past, n_rep;

		function void clear();
			time_limit = 0; first_arrival = 0; sim_clock = 0; next_arr = 0;
			next_dep = '1; busy = 0; waiting = 0; arrivals = 0; departures = 0;
			area_total = 0; area_queue = 0; area_busy = 0;
		endfunction

		function void write_reg(logic idx, bit [31:0] val);
			if (idx == CFG_TIME_LIMIT) begin
				time_limit = val;
			end else begin
				first_arrival = val;
				if (arrivals == 0) next_arr = val;
			end
		endfunction

		function bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b);
			bit [64:0] s;
			s = a + b;
			return s[64] ? '1 : s[63:0];
		endfunction

		function bit [63:0] sat_prod(bit [63:0] a, bit [63:0] b);
			bit [127:0] p;
			p = a * b;
			return (p[127:64] != 0) ? '1 : p[63:0];
		endfunction

		function bit [31:0] later(bit [31:0] t, bit [31:0] d);
			bit [32:0] s;
			s = t + d;
			return s[32] ? '1 : s[31:0];
		endfunction

		// Delta is a 64-bit wrapped difference; an event behind the clock wraps
		function void add_area(bit [63:0] dt);
			area_total = sat_sum(area_total, sat_prod(dt, waiting + busy));
			area_queue = sat_sum(area_queue, sat_prod(dt, waiting));
			area_busy = sat_sum(area_busy, sat_prod(dt, busy));
		endfunction

		function bit [31:0] ratio(bit [255:0] num, bit [63:0] den);
			bit [255:0] q;
			if (den == 0) return 0;
			q = num / den;
			return (q > 32'hFFFF_FFFF) ? '1 : q[31:0];
		endfunction

		// Note an accepted command beat and queue its expected result
		function void note_command(logic op, bit [31:0] ia, bit [31:0] sv);
			ssq_result_t r;
			bit dep_due, arr_due;
			r = '0;
			if (op == OP_STEP) begin
				dep_due = busy && next_dep <= time_limit;
				arr_due = next_arr <= time_limit;
				if (sim_clock > time_limit || (!dep_due && !arr_due)) begin
					r.kind = KIND_PAST; n_past++;
				end else if (!busy || next_arr < next_dep) begin
					r.kind = KIND_ARRIVAL; n_arr++;
					if (arrivals != '1) arrivals++;
					add_area(64'(next_arr) - 64'(sim_clock));
					sim_clock = next_arr;
					next_arr = later(sim_clock, ia);
					if (!busy) begin
						busy = 1;
						next_dep = later(sim_clock, sv);
					end else if (waiting != '1) begin
						waiting++;
					end
				end else begin
					r.kind = KIND_DEPARTURE; n_dep++;
					if (departures != '1) departures++;
					add_area(64'(next_dep) - 64'(sim_clock));
					sim_clock = next_dep;
					if (waiting > 0) begin
						waiting--;
						next_dep = later(sim_clock, sv);
					end else begin
						busy = 0;
						next_dep = '1;
					end
				end
			end else begin
				r.kind = KIND_REPORT; n_rep++;
				if (time_limit > sim_clock) begin
					add_area(64'(time_limit - sim_clock));
					sim_clock = time_limit;
				end
				r.sojourn = ratio(area_total, arrivals);
				r.wait_avg = ratio(area_queue, arrivals);
				r.in_system = ratio({area_total, 16'h0}, time_limit);
				r.util = ratio({area_busy * 256'd100, 16'h0}, time_limit);
				r.arr_rate = ratio({arrivals, 32'h0}, time_limit);
				r.svc_rate = ratio({departures, 32'h0}, area_busy);
			end
			r.clock_now = sim_clock; r.queue_count = waiting; r.busy = busy;
			r.arrived = arrivals; r.produced = departures;
			pending.push_back(r);
		endfunction

		// Compare one result beat with the oldest expectation
		function void check_result(ssq_result_t got);
			ssq_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.kind != e.kind)
				$display("%0t: kind exp %0d got %0d", $time, e.kind, got.kind);
			if (got.clock_now != e.clock_now)
				$display("%0t: clock exp %h got %h", $time, e.clock_now, got.clock_now);
			if (got.queue_count != e.queue_count)
				$display("%0t: queue exp %0d got %0d", $time, e.queue_count, got.queue_count);
			if (got.busy != e.busy)
				$display("%0t: busy exp %0d got %0d", $time, e.busy, got.busy);
			if (got.arrived != e.arrived)
				$display("%0t: arrivals exp %0d got %0d", $time, e.arrived, got.arrived);
			if (got.produced != e.produced)
				$display("%0t: departures exp %0d got %0d", $time, e.produced, got.produced);
			if (got.sojourn != e.sojourn)
				$display("%0t: sojourn exp %h got %h", $time, e.sojourn, got.sojourn);
			if (got.wait_avg != e.wait_avg)
				$display("%0t: wait exp %h got %h", $time, e.wait_avg, got.wait_avg);
			if (got.in_system != e.in_system)
				$display("%0t: in system exp %h got %h", $time, e.in_system, got.in_system);
			if (got.util != e.util)
				$display("%0t: utilization exp %h got %h", $time, e.util, got.util);
			if (got.arr_rate != e.arr_rate)
				$display("%0t: arrival rate exp %h got %h", $time, e.arr_rate, got.arr_rate);
			if (got.svc_rate != e.svc_rate)
				$display("%0t: service rate exp %h got %h", $time, e.svc_rate, got.svc_rate);
			if (got != e) errors++;
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [63:0]   s_axis_tdata;
	logic [0:0]    s_axis_tuser;
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [311:0]  m_axis_tdata;
	logic [1:0]    m_axis_tuser;
	logic          cfg_we;
	logic [0:0]    cfg_index;
	logic [31:0]   cfg_data;

	queue_scoreboard sb;
	bit              calm;      // no idling on either side while set

	single_server_queue_event_step dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Split a result beat into its fields
	function automatic ssq_result_t unpack_result(logic [1:0] u, logic [311:0] d);
		ssq_result_t r;
		r.kind        = u;
		r.clock_now   = d[31:0];
		r.queue_count = d[47:32];
		r.busy        = d[48];
		r.arrived     = d[80:49];
		r.produced    = d[112:81];
		r.sojourn     = d[144:113];
		r.wait_avg    = d[176:145];
		r.in_system   = d[208:177];
		r.util        = d[240:209];
		r.arr_rate    = d[272:241];
		r.svc_rate    = d[304:273];
		return r;
	endfunction

	// Result side: random stall, check each accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(unpack_result(m_axis_tuser, m_axis_tdata));
			m_axis_tready <= calm || ($urandom_range(99) >= 37);
		end
	end

	// Send one command beat, with a random gap before it; valid stays up
	// after the accept until the next gap or drain drops it
	task automatic send_cmd(logic op, bit [31:0] ia, bit [31:0] sv);
		while (!calm && $urandom_range(99) < 37) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= {sv, ia};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_command(op, ia, sv);
	endtask

	// Let every expected beat arrive, then settle before a register write
	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, bit [31:0] val);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
	endtask

	function automatic bit [31:0] rnd_time();
		case ($urandom_range(9))
			0: return '1;
			1: return 0;
			2: return $urandom;
			default: return $urandom_range(32'h0004_0000);
		endcase
	endfunction

	initial begin
		int phase, k, len;
		bit [31:0] lim;
		sb = new();
		sb.clear();
		calm = 0;
		arst_n = 0;
		s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = OP_STEP;
		m_axis_tready = 0;
		cfg_we = 0; cfg_index = CFG_TIME_LIMIT; cfg_data = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: zero limit, late first arrival, extremes, finish twice
		send_cmd(OP_STEP, 0, 0);
		send_cmd(OP_FINISH, 0, 0);
		drain();
		write_reg(CFG_FIRST_ARRIVAL, 32'h0001_0000);
		write_reg(CFG_TIME_LIMIT, 32'h0010_0000);
		send_cmd(OP_STEP, 32'h0000_8000, 32'h0003_0000);
		send_cmd(OP_STEP, 32'h0000_8000, 32'h0001_0000);
		send_cmd(OP_STEP, 32'h0000_4000, '1);
		send_cmd(OP_STEP, 32'h0000_4000, 32'h0000_0001);
		send_cmd(OP_STEP, '1, '1);
		send_cmd(OP_STEP, 0, 0);
		send_cmd(OP_STEP, 32'hAAAA_AAAA, 32'h5555_5555);
		send_cmd(OP_STEP, 32'h5555_5555, 32'hAAAA_AAAA);
		send_cmd(OP_FINISH, '1, '1);
		send_cmd(OP_FINISH, 0, 0);
		send_cmd(OP_STEP, 0, 0);
		// Pause until every result is back
		drain();

		// Random phases; limits swing between extremes and typical values
		for (phase = 0; phase < 24; phase++) begin
			calm = (phase == 5);
			drain();
			case (phase % 4)
				0: lim = '1;
				1: lim = $urandom_range(32'h0040_0000, 32'h0200_0000);
				2: lim = $urandom;
				default: lim = $urandom_range(32'h0000_1000);
			endcase
			write_reg(CFG_TIME_LIMIT, lim);
			write_reg(CFG_FIRST_ARRIVAL, rnd_time());
			len = $urandom_range(40, 70);
			for (k = 0; k < len; k++) begin
				if ($urandom_range(29) == 0)
					send_cmd(OP_FINISH, $urandom, $urandom);
				else if ($urandom_range(3) == 0)
					// bursty arrivals build the queue
					send_cmd(OP_STEP, $urandom_range(32'h2000), rnd_time());
				else
					send_cmd(OP_STEP, rnd_time(), rnd_time());
			end
			send_cmd(OP_FINISH, $urandom, $urandom);
		end
		calm = 0;
		drain();
		repeat (100) @(posedge clk);
		$display("covered %0d arrivals, %0d departures, %0d past-limit steps, %0d reports",
			sb.n_arr, sb.n_dep, sb.n_past, sb.n_rep);
		$display("over 24 limit settings from zero through full scale");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("single_server_queue_event_step test passed");
		else
			$display("single_server_queue_event_step test failed");
		$finish;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#60ms;
		$display("single_server_queue_event_step test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ssq_pkg.sv
hdl/ssq_mul_acc.sv
hdl/ssq_divider.sv
hdl/single_server_queue_event_step.sv
bench/tb_single_server_queue_event_step.sv
